// ===== rtl/core/ple_pkg.sv =====
// ple_pkg: shared types and constants for the positional list engine
// operation and status codes, field widths, and the cell command bundle
// no dependencies
package ple_pkg;

    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int POS_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;
    localparam int GROUP_N     = 8;

    localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_RETRIEVE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_REPLACE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

    // broadcast to every cell in the cycle a beat is taken
    typedef struct packed {
        logic ins;   // open a gap at pos, shift the tail up
        logic rem;   // close the slot at pos, shift the tail down
        logic repl;  // overwrite the slot at pos
        logic rd;    // drive the slot at pos onto the read tree
    } ple_cmd_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
// ple_cell: one list slot with its neighbor shift muxes
// depends on ple_pkg
module ple_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 8
) (
    input  logic                     aclk,
    input  ple_pkg::ple_cmd_t        cmd_i,
    input  logic [IDX_W-1:0]         pos_i,
    input  logic [ple_pkg::DATA_W-1:0] value_i,
    input  logic [ple_pkg::DATA_W-1:0] left_i,
    input  logic [ple_pkg::DATA_W-1:0] right_i,
    output logic [ple_pkg::DATA_W-1:0] slot_o,
    output logic [ple_pkg::DATA_W-1:0] hit_o
);
    import ple_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] slot_reg;
    logic [DATA_W-1:0] slot_next;
    logic              at_pos;
    logic              above_pos;

    assign at_pos    = (pos_i == MY_IDX);
    assign above_pos = (MY_IDX > pos_i);

    always_comb begin
        slot_next = slot_reg;
        priority if (cmd_i.ins && at_pos) begin
            slot_next = value_i;
        end else if (cmd_i.ins && above_pos) begin
            slot_next = left_i;
        end else if (cmd_i.rem && (at_pos || above_pos)) begin
            slot_next = right_i;
        end else if (cmd_i.repl && at_pos) begin
            slot_next = value_i;
        end else begin
            slot_next = slot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot_o = slot_reg;
    assign hit_o  = (cmd_i.rd && at_pos) ? slot_reg : '0;

endmodule

// ===== rtl/core/ple_rdgroup.sv =====
// ple_rdgroup: registered or-reduction of one group of cell read taps
// depends on ple_pkg
module ple_rdgroup (
    input  logic                                        aclk,
    input  logic                                        en_i,
    input  logic [ple_pkg::GROUP_N-1:0][ple_pkg::DATA_W-1:0] hit_i,
    output logic [ple_pkg::DATA_W-1:0]                  part_o
);
    import ple_pkg::*;

    logic [DATA_W-1:0] part_reg;
    logic [DATA_W-1:0] part_next;

    always_comb begin
        part_next = '0;
        for (int k = 0; k < GROUP_N; k++) begin
            part_next = part_next | hit_i[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            part_reg <= part_next;
        end
    end

    assign part_o = part_reg;

endmodule

// ===== rtl/core/positional_list_engine_core.sv =====
// positional_list_engine_core: bounded ordered list held in a row of shifting cells
// depends on ple_pkg, ple_cell, ple_rdgroup
//
//  channel | dir | beat fields (tdata, low bit up)
//  s_      | in  | func[2:0] position[8:3] entry_value[40:9], zero pad to 48
//  m_      | out | status[1:0] read_value[33:2] entry_count[40:34]
//          |     | is_full[41] is_empty[42], zero pad to 48
//
// one beat per cycle sustained while the m_ side does not stall; a result passes the
// cell row plus one registered read-tree level, then the output register
// the cells at and above the position shift from their neighbors in the cycle the beat
// is taken, so the next beat already sees the updated list
// aresetn clears the count and the pipeline valids; slot contents stay undefined
// a stalled m_ side holds the output register and back-pressures s_tready
module positional_list_engine_core #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ple_pkg::IN_TDATA_W-1:0]    s_tdata,   // func, position, entry_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ple_pkg::OUT_TDATA_W-1:0]   m_tdata    // status, read_value, entry_count,
                                                         // is_full, is_empty
);
    import ple_pkg::*;

    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int WW     = CW + POS_W;
    localparam int NG     = (MAX_ENTRIES + GROUP_N - 1) / GROUP_N;
    localparam int NCELLS = NG * GROUP_N;
    localparam int OUT_USED_W = STATUS_W + DATA_W + COUNT_OUT_W + 2;

    // input beat fields
    logic [FUNC_W-1:0] in_func;
    logic [POS_W-1:0]  in_pos;
    logic [DATA_W-1:0] in_value;

    assign in_func  = s_tdata[FUNC_W-1:0];
    assign in_pos   = s_tdata[FUNC_W+POS_W-1:FUNC_W];
    assign in_value = s_tdata[FUNC_W+POS_W+DATA_W-1:FUNC_W+POS_W];

    // list count
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [WW-1:0] pos_w;
    logic [WW-1:0] cnt_w;
    logic          list_full;
    logic          list_empty;

    assign pos_w      = WW'(in_pos);
    assign cnt_w      = WW'(count_reg);
    assign list_full  = (count_reg == CW'(MAX_ENTRIES));
    assign list_empty = (count_reg == '0);

    // pipeline handshake
    logic s_fire;
    logic v1_reg;
    logic adv1;
    logic m_valid_reg;

    assign adv1     = v1_reg && (!m_valid_reg || m_tready);
    assign s_tready = !v1_reg || adv1;
    assign s_fire   = s_tvalid && s_tready;

    // decode and status
    ple_cmd_t          cmd;
    ple_cmd_t          cmd_apply;
    logic [STATUS_W-1:0] status_d;

    always_comb begin
        cmd        = '0;
        status_d   = ST_OK;
        count_next = count_reg;
        unique case (in_func)
            FUNC_INSERT: begin
                if (list_full) begin
                    status_d = ST_OVERFLOW;
                end else if (pos_w > cnt_w) begin
                    status_d = ST_RANGE;
                end else begin
                    cmd.ins    = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_RETRIEVE, FUNC_REPLACE, FUNC_REMOVE: begin
                if (list_empty) begin
                    status_d = ST_UNDER;
                end else if (pos_w >= cnt_w) begin
                    status_d = ST_RANGE;
                end else begin
                    cmd.rd   = (in_func != FUNC_REPLACE);
                    cmd.repl = (in_func == FUNC_REPLACE);
                    if (in_func == FUNC_REMOVE) begin
                        cmd.rem    = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            FUNC_CLEAR: begin
                count_next = '0;
            end
            default: begin
                // unused codes leave the list alone and report success
                count_next = count_reg;
            end
        endcase
    end

    assign cmd_apply = s_fire ? cmd : '0;

    // row of cells, padded to whole read groups; pad cells never match a position
    logic [NCELLS-1:0][DATA_W-1:0] slot_q;
    logic [NCELLS-1:0][DATA_W-1:0] hit_q;
    logic [NG-1:0][DATA_W-1:0]     part_q;

    for (genvar gi = 0; gi < NCELLS; gi++) begin : g_cell
        if (gi < MAX_ENTRIES) begin : g_live
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (gi == 0) begin : g_first
                assign left_d = '0;
            end else begin : g_mid_l
                assign left_d = slot_q[gi-1];
            end
            if (gi == MAX_ENTRIES - 1) begin : g_last
                assign right_d = slot_q[gi];
            end else begin : g_mid_r
                assign right_d = slot_q[gi+1];
            end
            ple_cell #(
                .INDEX (gi),
                .IDX_W (WW)
            ) u_cell (
                .aclk    (aclk),
                .cmd_i   (cmd_apply),
                .pos_i   (pos_w),
                .value_i (in_value),
                .left_i  (left_d),
                .right_i (right_d),
                .slot_o  (slot_q[gi]),
                .hit_o   (hit_q[gi])
            );
        end else begin : g_pad
            assign slot_q[gi] = '0;
            assign hit_q[gi]  = '0;
        end
    end

    // first read-tree level, captured with the pre-shift slot values
    for (genvar gg = 0; gg < NG; gg++) begin : g_grp
        ple_rdgroup u_grp (
            .aclk   (aclk),
            .en_i   (s_fire),
            .hit_i  (hit_q[gg*GROUP_N +: GROUP_N]),
            .part_o (part_q[gg])
        );
    end

    // stage one control
    logic [STATUS_W-1:0] st1_reg;
    logic [CW-1:0]       cnt1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            count_reg <= '0;
        end else begin
            if (s_fire) begin
                v1_reg    <= 1'b1;
                count_reg <= count_next;
            end else if (adv1) begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_reg  <= status_d;
            cnt1_reg <= count_next;
        end
    end

    // second read-tree level into the output register
    logic [DATA_W-1:0]      rd_merge;
    logic [WW-1:0]          cnt1_w;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [DATA_W-1:0]      m_read_reg;
    logic [COUNT_OUT_W-1:0] m_count_reg;
    logic                   m_full_reg;
    logic                   m_empty_reg;

    always_comb begin
        rd_merge = '0;
        for (int g = 0; g < NG; g++) begin
            rd_merge = rd_merge | part_q[g];
        end
    end

    assign cnt1_w = WW'(cnt1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            m_status_reg <= st1_reg;
            m_read_reg   <= rd_merge;
            m_count_reg  <= cnt1_w[COUNT_OUT_W-1:0];
            m_full_reg   <= (cnt1_reg == CW'(MAX_ENTRIES));
            m_empty_reg  <= (cnt1_reg == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}},
                       m_empty_reg, m_full_reg, m_count_reg, m_read_reg, m_status_reg};

    // count never runs past capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("list count above capacity");

    // the count moves only on a taken beat
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(count_reg))
        else $error("list count changed without a beat");

    // a failed operation returns no entry
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK) |-> (m_read_reg == '0))
        else $error("failed operation returned data");

    // full and empty flags exclude each other
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_full_reg && m_empty_reg))
        else $error("full and empty both set");

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_read_reg)))
        else $error("stalled result changed");

endmodule
